@@ hw/rtl/rcpc_pkg.sv @@
// Shared types and constants for the RC pulse-width capture block.
// No dependencies; used by rcpc_channel and rc_pwm_pulse_capture.
package rcpc_pkg;

  // Number of implemented capture channels (0..2); forward is 0, steer is 1
  localparam int CHANNELS = 2;
  // Channels that the pin routing can address
  localparam int ROUTED   = 2;
  localparam int CH_FWD   = 0;
  localparam int CH_STR   = 1;

  localparam int PIN_W    = 5;
  localparam int WIDTH_W  = 16;
  localparam int STAMP_W  = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORWARD_PIN = 2'd0,
    REG_STEER_PIN   = 2'd1,
    REG_MIN_WIDTH   = 2'd2,
    REG_MAX_WIDTH   = 2'd3
  } cfg_reg_e;

  localparam logic [PIN_W-1:0]   FORWARD_PIN_RST = 5'd0;
  localparam logic [PIN_W-1:0]   STEER_PIN_RST   = 5'd1;
  localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST   = 16'd800;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST   = 16'd2200;

  // Edge event as seen by one channel
  typedef struct packed {
    logic                 hit;
    logic                 rise;
    logic                 fall;
    logic [STAMP_W-1:0]   now;
  } chan_evt_t;

  // Channel snapshot after an event
  typedef struct packed {
    logic [WIDTH_W-1:0]   width;
    logic [STAMP_W-1:0]   stamp;
    logic                 seen;
    logic                 acc;
  } chan_stat_t;

endpackage

@@ hw/rtl/rcpc_channel.sv @@
// One pulse capture channel: rise time, level, last accepted width and stamp.
// Depends on rcpc_pkg for the event and snapshot structs.
module rcpc_channel (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  rcpc_pkg::chan_evt_t           evt,
  input  logic [rcpc_pkg::WIDTH_W-1:0]  min_width,
  input  logic [rcpc_pkg::WIDTH_W-1:0]  max_width,
  output rcpc_pkg::chan_stat_t          stat_nxt
);

  logic [rcpc_pkg::STAMP_W-1:0] rise_stamp_r, rise_stamp_nxt;
  logic                         level_high_r, level_high_nxt;
  logic [rcpc_pkg::WIDTH_W-1:0] width_r;
  logic [rcpc_pkg::STAMP_W-1:0] stamp_r;
  logic                         seen_r;
  logic [rcpc_pkg::STAMP_W-1:0] delta;
  logic                         level_after_rise;
  logic                         do_fall;
  logic                         in_range;
  logic                         acc;

  // Apply the rise first, then the fall against the updated state
  always_comb begin
    rise_stamp_nxt   = evt.rise ? evt.now : rise_stamp_r;
    level_after_rise = evt.rise | level_high_r;
    do_fall          = evt.fall & level_after_rise;
    level_high_nxt   = level_after_rise & ~evt.fall;
    delta            = evt.now - rise_stamp_nxt;
    // Upper bits must be clear for the width to fit the 16-bit bounds
    in_range = (delta[rcpc_pkg::STAMP_W-1:rcpc_pkg::WIDTH_W] == '0) &&
               (delta[rcpc_pkg::WIDTH_W-1:0] >= min_width) &&
               (delta[rcpc_pkg::WIDTH_W-1:0] <= max_width);
    acc = evt.hit & do_fall & in_range;
  end

  // Snapshot as it stands after this event
  always_comb begin
    stat_nxt.width = acc ? delta[rcpc_pkg::WIDTH_W-1:0] : width_r;
    stat_nxt.stamp = acc ? evt.now : stamp_r;
    stat_nxt.seen  = acc | seen_r;
    stat_nxt.acc   = acc;
  end

  // Hold the rise time until the next rise routed here; it has no reset
  always_ff @(posedge clk) begin
    if (en && evt.hit) begin
      rise_stamp_r <= rise_stamp_nxt;
    end
  end

  // Advance channel state on each request routed here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_high_r <= 1'b0;
      width_r      <= '0;
      stamp_r      <= '0;
      seen_r       <= 1'b0;
    end else if (en && evt.hit) begin
      level_high_r <= level_high_nxt;
      width_r      <= stat_nxt.width;
      stamp_r      <= stat_nxt.stamp;
      seen_r       <= stat_nxt.seen;
    end
  end

endmodule

@@ hw/rtl/rc_pwm_pulse_capture.sv @@
// Top level of the two-channel RC servo pulse-width capture block.
// Depends on rcpc_pkg and rcpc_channel.
//
// Each request is one pin edge event; it is routed to the forward channel if
// its pin matches forward_pin, else to the steer channel if it matches
// steer_pin, else it changes nothing. Every request yields one result with
// the snapshot of both channels after the event and an accepted flag. The
// block sustains one request per clock while results are taken: a request is
// held in the input register, where a 64-bit subtract and two 16-bit compares
// update the channel state and load the result register, which raises
// out_valid. While a result waits, the input register still takes one more
// request; in_ready then stays low until the result is taken.
// Configuration writes are taken at any time (cfg_ready is always high) but
// must only be issued while the block is idle.
module rc_pwm_pulse_capture (
  input  logic                              clk,
  input  logic                              rst_n,
  // edge event requests
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rcpc_pkg::PIN_W-1:0]        in_pin,
  input  logic                              in_rise_edge,
  input  logic                              in_fall_edge,
  input  logic [rcpc_pkg::STAMP_W-1:0]      in_now_us,
  // snapshot results
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rcpc_pkg::WIDTH_W-1:0]      out_fwd_width_us,
  output logic [rcpc_pkg::STAMP_W-1:0]      out_fwd_stamp_us,
  output logic                              out_fwd_valid,
  output logic [rcpc_pkg::WIDTH_W-1:0]      out_str_width_us,
  output logic [rcpc_pkg::STAMP_W-1:0]      out_str_stamp_us,
  output logic                              out_str_valid,
  output logic                              out_accepted,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rcpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcpc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [rcpc_pkg::PIN_W-1:0]   forward_pin_r;
  logic [rcpc_pkg::PIN_W-1:0]   steer_pin_r;
  logic [rcpc_pkg::WIDTH_W-1:0] min_width_r;
  logic [rcpc_pkg::WIDTH_W-1:0] max_width_r;

  logic                         in_valid_r;
  logic [rcpc_pkg::PIN_W-1:0]   pin_r;
  logic                         rise_r;
  logic                         fall_r;
  logic [rcpc_pkg::STAMP_W-1:0] now_r;

  logic                         out_valid_r;
  logic [rcpc_pkg::WIDTH_W-1:0] fwd_width_r, str_width_r;
  logic [rcpc_pkg::STAMP_W-1:0] fwd_stamp_r, str_stamp_r;
  logic                         fwd_seen_r, str_seen_r;
  logic                         accepted_r;

  logic                         advance;
  logic                         fire;
  logic [rcpc_pkg::ROUTED-1:0]  hit;
  rcpc_pkg::chan_stat_t         stat [rcpc_pkg::ROUTED];

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      forward_pin_r <= rcpc_pkg::FORWARD_PIN_RST;
      steer_pin_r   <= rcpc_pkg::STEER_PIN_RST;
      min_width_r   <= rcpc_pkg::MIN_WIDTH_RST;
      max_width_r   <= rcpc_pkg::MAX_WIDTH_RST;
    end else if (cfg_valid) begin
      unique case (rcpc_pkg::cfg_reg_e'(cfg_index))
        rcpc_pkg::REG_FORWARD_PIN: forward_pin_r <= cfg_data[rcpc_pkg::PIN_W-1:0];
        rcpc_pkg::REG_STEER_PIN:   steer_pin_r   <= cfg_data[rcpc_pkg::PIN_W-1:0];
        rcpc_pkg::REG_MIN_WIDTH:   min_width_r   <= cfg_data;
        rcpc_pkg::REG_MAX_WIDTH:   max_width_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage moves when the result register is free or being drained
  assign advance  = !out_valid_r || out_ready;
  assign fire     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pin_r  <= in_pin;
      rise_r <= in_rise_edge;
      fall_r <= in_fall_edge;
      now_r  <= in_now_us;
    end
  end

  // Route the pin: forward wins when both pins match
  assign hit[rcpc_pkg::CH_FWD] = (pin_r == forward_pin_r);
  assign hit[rcpc_pkg::CH_STR] = (pin_r != forward_pin_r) && (pin_r == steer_pin_r);

  // Instantiate implemented channels; absent ones read as zero
  for (genvar ch = 0; ch < rcpc_pkg::ROUTED; ch++) begin : g_chan
    if (ch < rcpc_pkg::CHANNELS) begin : g_on
      rcpc_pkg::chan_evt_t evt;
      always_comb begin
        evt.hit  = hit[ch];
        evt.rise = rise_r;
        evt.fall = fall_r;
        evt.now  = now_r;
      end
      rcpc_channel u_chan (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (fire),
        .evt       (evt),
        .min_width (min_width_r),
        .max_width (max_width_r),
        .stat_nxt  (stat[ch])
      );
    end else begin : g_off
      assign stat[ch] = '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      fwd_width_r <= stat[rcpc_pkg::CH_FWD].width;
      fwd_stamp_r <= stat[rcpc_pkg::CH_FWD].stamp;
      fwd_seen_r  <= stat[rcpc_pkg::CH_FWD].seen;
      str_width_r <= stat[rcpc_pkg::CH_STR].width;
      str_stamp_r <= stat[rcpc_pkg::CH_STR].stamp;
      str_seen_r  <= stat[rcpc_pkg::CH_STR].seen;
      accepted_r  <= stat[rcpc_pkg::CH_FWD].acc | stat[rcpc_pkg::CH_STR].acc;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fwd_width_us = fwd_width_r;
  assign out_fwd_stamp_us = fwd_stamp_r;
  assign out_fwd_valid    = fwd_seen_r;
  assign out_str_width_us = str_width_r;
  assign out_str_stamp_us = str_stamp_r;
  assign out_str_valid    = str_seen_r;
  assign out_accepted     = accepted_r;

endmodule

@@ tb/tb_rc_pwm_pulse_capture.sv @@
// Self-checking testbench for the RC pulse-width capture block: a predictor
// class tracks both channels and checks every snapshot in order.
// Depends on rcpc_pkg and the rc_pwm_pulse_capture RTL.
module tb_rc_pwm_pulse_capture;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [rcpc_pkg::STAMP_W-1:0] STAMP_MAX = '1;

  // Snapshot of both channels as returned for one edge event
  typedef struct packed {
    logic [rcpc_pkg::WIDTH_W-1:0] fwd_width;
    logic [rcpc_pkg::STAMP_W-1:0] fwd_stamp;
    logic                         fwd_seen;
    logic [rcpc_pkg::WIDTH_W-1:0] str_width;
    logic [rcpc_pkg::STAMP_W-1:0] str_stamp;
    logic                         str_seen;
    logic                         taken;
  } snapshot_t;

  // Predicts the snapshot of each edge event and checks results in order
  class capture_predictor;
    logic [rcpc_pkg::PIN_W-1:0]   fwd_pin;
    logic [rcpc_pkg::PIN_W-1:0]   str_pin;
    logic [rcpc_pkg::WIDTH_W-1:0] min_w;
    logic [rcpc_pkg::WIDTH_W-1:0] max_w;
    logic [rcpc_pkg::STAMP_W-1:0] rise_t [rcpc_pkg::ROUTED];
    logic                         high   [rcpc_pkg::ROUTED];
    logic [rcpc_pkg::WIDTH_W-1:0] width  [rcpc_pkg::ROUTED];
    logic [rcpc_pkg::STAMP_W-1:0] stamp  [rcpc_pkg::ROUTED];
    logic                         seen   [rcpc_pkg::ROUTED];
    snapshot_t                    snapshots_due[$];
    int                           errors;
    int                           n_events;
    int                           n_checked;
    int                           n_taken;
    int                           n_writes;

    function new();
      fwd_pin = rcpc_pkg::FORWARD_PIN_RST;
      str_pin = rcpc_pkg::STEER_PIN_RST;
      min_w   = rcpc_pkg::MIN_WIDTH_RST;
      max_w   = rcpc_pkg::MAX_WIDTH_RST;
      for (int i = 0; i < rcpc_pkg::ROUTED; i++) begin
        rise_t[i] = '0;
        high[i]   = 1'b0;
        width[i]  = '0;
        stamp[i]  = '0;
        seen[i]   = 1'b0;
      end
      errors    = 0;
      n_events  = 0;
      n_checked = 0;
      n_taken   = 0;
      n_writes  = 0;
    endfunction

    function void write_reg(rcpc_pkg::cfg_reg_e idx, logic [rcpc_pkg::CFG_DATA_W-1:0] data);
      n_writes++;
      case (idx)
        rcpc_pkg::REG_FORWARD_PIN: fwd_pin = data[rcpc_pkg::PIN_W-1:0];
        rcpc_pkg::REG_STEER_PIN:   str_pin = data[rcpc_pkg::PIN_W-1:0];
        rcpc_pkg::REG_MIN_WIDTH:   min_w   = data[rcpc_pkg::WIDTH_W-1:0];
        rcpc_pkg::REG_MAX_WIDTH:   max_w   = data[rcpc_pkg::WIDTH_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the channel state for one accepted request, queue its snapshot
    function void note_edge(logic [rcpc_pkg::PIN_W-1:0] pin, logic rise, logic fall,
                            logic [rcpc_pkg::STAMP_W-1:0] now);
      int                           ch;
      logic                         hit;
      logic                         acc;
      logic [rcpc_pkg::STAMP_W-1:0] w;
      snapshot_t                    s;
      hit = 1'b1;
      acc = 1'b0;
      ch  = rcpc_pkg::CH_FWD;
      if (pin == fwd_pin) ch = rcpc_pkg::CH_FWD;
      else if (pin == str_pin) ch = rcpc_pkg::CH_STR;
      else hit = 1'b0;
      if (hit && ch < rcpc_pkg::CHANNELS) begin
        if (rise) begin
          rise_t[ch] = now;
          high[ch]   = 1'b1;
        end
        if (fall && high[ch]) begin
          w        = now - rise_t[ch];
          high[ch] = 1'b0;
          if (w >= min_w && w <= max_w) begin
            width[ch] = w[rcpc_pkg::WIDTH_W-1:0];
            stamp[ch] = now;
            seen[ch]  = 1'b1;
            acc       = 1'b1;
          end
        end
      end
      // channels that are not built read back as zero
      s.fwd_width = (rcpc_pkg::CH_FWD < rcpc_pkg::CHANNELS) ? width[rcpc_pkg::CH_FWD] : '0;
      s.fwd_stamp = (rcpc_pkg::CH_FWD < rcpc_pkg::CHANNELS) ? stamp[rcpc_pkg::CH_FWD] : '0;
      s.fwd_seen  = (rcpc_pkg::CH_FWD < rcpc_pkg::CHANNELS) ? seen[rcpc_pkg::CH_FWD]  : 1'b0;
      s.str_width = (rcpc_pkg::CH_STR < rcpc_pkg::CHANNELS) ? width[rcpc_pkg::CH_STR] : '0;
      s.str_stamp = (rcpc_pkg::CH_STR < rcpc_pkg::CHANNELS) ? stamp[rcpc_pkg::CH_STR] : '0;
      s.str_seen  = (rcpc_pkg::CH_STR < rcpc_pkg::CHANNELS) ? seen[rcpc_pkg::CH_STR]  : 1'b0;
      s.taken     = acc;
      snapshots_due.push_back(s);
      n_events++;
      if (acc) n_taken++;
    endfunction

    function void compare_field(string name, logic [rcpc_pkg::STAMP_W-1:0] want,
                                logic [rcpc_pkg::STAMP_W-1:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_snapshot(snapshot_t got);
      snapshot_t want;
      if (snapshots_due.size() == 0) begin
        $display("%0t ns: result with no request pending, expected none, actual %0h",
                 $time, got);
        errors++;
      end else begin
        want = snapshots_due.pop_front();
        n_checked++;
        compare_field("fwd_width_us", want.fwd_width, got.fwd_width);
        compare_field("fwd_stamp_us", want.fwd_stamp, got.fwd_stamp);
        compare_field("fwd_valid",    want.fwd_seen,  got.fwd_seen);
        compare_field("str_width_us", want.str_width, got.str_width);
        compare_field("str_stamp_us", want.str_stamp, got.str_stamp);
        compare_field("str_valid",    want.str_seen,  got.str_seen);
        compare_field("accepted",     want.taken,     got.taken);
      end
    endfunction

    function int pending();
      return snapshots_due.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [rcpc_pkg::PIN_W-1:0]      in_pin;
  logic                            in_rise_edge;
  logic                            in_fall_edge;
  logic [rcpc_pkg::STAMP_W-1:0]    in_now_us;
  logic                            out_valid;
  logic                            out_ready;
  logic [rcpc_pkg::WIDTH_W-1:0]    out_fwd_width_us;
  logic [rcpc_pkg::STAMP_W-1:0]    out_fwd_stamp_us;
  logic                            out_fwd_valid;
  logic [rcpc_pkg::WIDTH_W-1:0]    out_str_width_us;
  logic [rcpc_pkg::STAMP_W-1:0]    out_str_stamp_us;
  logic                            out_str_valid;
  logic                            out_accepted;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [rcpc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rcpc_pkg::CFG_DATA_W-1:0] cfg_data;

  capture_predictor             sb;
  int                           burst_left;
  logic [rcpc_pkg::STAMP_W-1:0] t_base;
  int                           n_phases;

  rc_pwm_pulse_capture dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pin           (in_pin),
    .in_rise_edge     (in_rise_edge),
    .in_fall_edge     (in_fall_edge),
    .in_now_us        (in_now_us),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_fwd_width_us (out_fwd_width_us),
    .out_fwd_stamp_us (out_fwd_stamp_us),
    .out_fwd_valid    (out_fwd_valid),
    .out_str_width_us (out_str_width_us),
    .out_str_stamp_us (out_str_stamp_us),
    .out_str_valid    (out_str_valid),
    .out_accepted     (out_accepted),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Stall the result channel: phases of always ready, random and mostly stalled
  initial begin
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Check each result taken at a rising edge
  initial begin
    snapshot_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.fwd_width = out_fwd_width_us;
        got.fwd_stamp = out_fwd_stamp_us;
        got.fwd_seen  = out_fwd_valid;
        got.str_width = out_str_width_us;
        got.str_stamp = out_str_stamp_us;
        got.str_seen  = out_str_valid;
        got.taken     = out_accepted;
        sb.check_snapshot(got);
      end
    end
  end

  // Send one edge event; the sender sometimes idles between bursts of random length
  task automatic send_event(logic [rcpc_pkg::PIN_W-1:0] pin, logic rise, logic fall,
                            logic [rcpc_pkg::STAMP_W-1:0] now);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_pin       <= pin;
    in_rise_edge <= rise;
    in_fall_edge <= fall;
    in_now_us    <= now;
    do @(posedge clk); while (!in_ready);
    sb.note_edge(pin, rise, fall, now);
  endtask

  // Hold off until every snapshot is back, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(rcpc_pkg::cfg_reg_e idx, logic [rcpc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Reprogram all registers while idle; pin writes carry junk in the upper bits
  task automatic program_regs(logic [rcpc_pkg::PIN_W-1:0] fwd, logic [rcpc_pkg::PIN_W-1:0] str,
                              logic [rcpc_pkg::WIDTH_W-1:0] mn,
                              logic [rcpc_pkg::WIDTH_W-1:0] mx);
    logic [rcpc_pkg::CFG_DATA_W-rcpc_pkg::PIN_W-1:0] junk;
    drain();
    junk = (rcpc_pkg::CFG_DATA_W - rcpc_pkg::PIN_W)'($urandom);
    write_reg(rcpc_pkg::REG_FORWARD_PIN, {junk, fwd});
    junk = (rcpc_pkg::CFG_DATA_W - rcpc_pkg::PIN_W)'($urandom);
    write_reg(rcpc_pkg::REG_STEER_PIN, {junk, str});
    write_reg(rcpc_pkg::REG_MIN_WIDTH, mn);
    write_reg(rcpc_pkg::REG_MAX_WIDTH, mx);
    n_phases++;
  endtask

  // Mostly rise/fall pairs on routed pins, plus noise and broken sequences
  task automatic run_items(int n);
    int                           done;
    int                           kind;
    int                           sel;
    logic [rcpc_pkg::PIN_W-1:0]   pin;
    logic [rcpc_pkg::STAMP_W-1:0] w;
    done = 0;
    while (done < n) begin
      if ($urandom_range(0, 19) == 0) t_base = {$urandom, $urandom};
      else t_base += $urandom_range(1, 5000);
      pin  = $urandom_range(0, 1) ? sb.str_pin : sb.fwd_pin;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        send_event(pin, 1'b1, 1'b0, t_base);
        done++;
        if ($urandom_range(0, 3) == 0) begin
          send_event(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), t_base + $urandom_range(0, 100));
          done++;
        end
        sel = $urandom_range(0, 9);
        if (sel < 6 && sb.min_w <= sb.max_w)
          w = sb.min_w + $urandom_range(0, sb.max_w - sb.min_w);
        else if (sel < 8) begin
          case ($urandom_range(0, 3))
            0:       w = sb.min_w - 1;
            1:       w = sb.min_w;
            2:       w = sb.max_w;
            default: w = sb.max_w + 1;
          endcase
        end else
          w = $urandom_range(0, 70000);
        send_event(pin, 1'b0, 1'b1, t_base + w);
        done++;
        t_base += w;
      end else if (kind < 80) begin
        send_event(pin, 1'b1, 1'b1, t_base);
        done++;
      end else if (kind < 90) begin
        send_event(pin, 1'b0, 1'b1, t_base);
        done++;
      end else begin
        send_event(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), {$urandom, $urandom});
        done++;
      end
    end
  endtask

  initial begin
    logic [rcpc_pkg::PIN_W-1:0]   a;
    logic [rcpc_pkg::PIN_W-1:0]   b;
    logic [rcpc_pkg::WIDTH_W-1:0] mn;
    logic [rcpc_pkg::WIDTH_W-1:0] mx;
    sb           = new();
    burst_left   = 0;
    t_base       = '0;
    n_phases     = 1;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_pin       = '0;
    in_rise_edge = 1'b0;
    in_fall_edge = 1'b0;
    in_now_us    = '0;
    cfg_valid    = 1'b0;
    cfg_index    = rcpc_pkg::REG_FORWARD_PIN;
    cfg_data     = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: range edges, steer channel, stray falls, unrouted pins, wrap
    send_event(5'd0, 1'b1, 1'b0, 64'd1000);
    send_event(5'd0, 1'b0, 1'b1, 64'd1800);
    send_event(5'd0, 1'b1, 1'b0, 64'd5000);
    send_event(5'd0, 1'b0, 1'b1, 64'd7200);
    send_event(5'd0, 1'b1, 1'b0, 64'd10000);
    send_event(5'd0, 1'b0, 1'b1, 64'd10799);
    send_event(5'd0, 1'b1, 1'b0, 64'd20000);
    send_event(5'd0, 1'b0, 1'b1, 64'd22201);
    send_event(5'd1, 1'b1, 1'b0, 64'd0);
    send_event(5'd1, 1'b0, 1'b1, 64'd1500);
    send_event(5'd1, 1'b0, 1'b1, 64'd1600);
    send_event(5'd5, 1'b1, 1'b1, 64'd2000);
    send_event(5'd0, 1'b1, 1'b1, 64'd30000);
    // counter wrap between rise and fall still gives a good width
    send_event(5'd0, 1'b1, 1'b0, STAMP_MAX);
    send_event(5'd0, 1'b0, 1'b1, 64'd999);
    // fall stamped before its rise
    send_event(5'd1, 1'b1, 1'b0, 64'd50000);
    send_event(5'd1, 1'b0, 1'b1, 64'd40000);
    send_event(5'd31, 1'b0, 1'b0, STAMP_MAX);
    send_event(5'd1, 1'b0, 1'b0, 64'd123);

    // Shared pin goes to forward; zero and full-scale widths pass
    program_regs(5'd31, 5'd31, 16'd0, 16'hFFFF);
    send_event(5'd31, 1'b1, 1'b1, 64'd77);
    send_event(5'd31, 1'b1, 1'b0, 64'd100);
    send_event(5'd31, 1'b0, 1'b1, 64'd100 + 64'd65535);

    // Minimum above maximum rejects everything
    program_regs(5'd31, 5'd31, 16'd3000, 16'd1000);
    send_event(5'd31, 1'b1, 1'b0, 64'd0);
    send_event(5'd31, 1'b0, 1'b1, 64'd2000);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: program_regs(5'd0, 5'd1, 16'd800, 16'd2200);
        1: program_regs(5'd31, 5'd0, 16'd0, 16'hFFFF);
        2: program_regs(5'd7, 5'd7, 16'd1000, 16'd2000);
        3: program_regs(5'd3, 5'd9, 16'd5000, 16'd1000);
        4: program_regs(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                        16'd60000, 16'hFFFF);
        default: begin
          a  = 5'($urandom_range(0, 31));
          b  = 5'($urandom_range(0, 31));
          mn = 16'($urandom_range(0, 4000));
          mx = mn + 16'($urandom_range(0, 3000));
          program_regs(a, b, mn, mx);
        end
      endcase
      run_items(230);
    end

    drain();
    $display("Checked %0d snapshots of %0d edge events, %0d pulses accepted.",
             sb.n_checked, sb.n_events, sb.n_taken);
    $display("Ran %0d register settings with %0d register writes, %0d mismatches.",
             n_phases, sb.n_writes, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
